FILE: src/md5_pkg.sv
// Shared types and constant tables for the MD5 hash engine.
package md5_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_part;
      logic        part_last;
   } rsp_type;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [31:0] K_TABLE [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] S_TABLE [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

endpackage

FILE: src/md5_hash_engine.sv
// MD5 hash engine: byte loader, padding sequencer and one shared round unit.
//
//   channel | direction | ports                                  | moves
//   --------+-----------+----------------------------------------+---------------------------
//   req     | in        | req_valid, req_stall, req_payload      | one byte and/or end mark
//   rsp     | out       | rsp_valid, rsp_stall, rsp_payload      | one 64-bit digest half
//
// Bytes are taken back to back while idle; the 64th byte of a block starts the 64 round
// steps of the single round unit and then the chaining update. An end transaction places
// the mark, fills the rest of the block with zeros and, when it fits, the bit length in
// words 14 and 15, then compresses it; when the length spills, a second block of zeros
// and length is filled and compressed, then the digest is loaded.
// Synchronous reset restores the initial chaining words and clears the byte count.
// req_stall is high whenever the sequencer is busy; a waiting digest half does
// not block byte transactions, only the next digest load.
module md5_hash_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  md5_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output md5_pkg::rsp_type  rsp_payload
);
   import md5_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_UPDATE,
      ST_MARK,
      ST_FILL,
      ST_DONE
   } state_type;

   state_type    state_ff, state_in;
   logic [31:0]  chain_a_ff, chain_a_in, chain_b_ff, chain_b_in;
   logic [31:0]  chain_c_ff, chain_c_in, chain_d_ff, chain_d_in;
   logic [31:0]  wa_ff, wa_in, wb_ff, wb_in, wc_ff, wc_in, wd_ff, wd_in;
   logic [60:0]  count_ff, count_in;
   logic [5:0]   step_ff, step_in;
   logic [4:0]   k_ff, k_in;
   logic         fin_ff, fin_in;
   logic         len_ff, len_in;
   logic         pend_last_ff, pend_last_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;
   logic [63:0]  hi_ff, hi_in;
   logic         hi_pend_ff, hi_pend_in;

   logic [31:0]  block_ff [16];

   logic         wr_en;
   logic [3:0]   wr_idx;
   logic [3:0]   wr_be;
   logic [31:0]  wr_data;

   logic         req_take, rsp_take, out_free;
   logic [5:0]   used;
   logic [63:0]  bit_len;
   logic [1:0]   rnd;
   logic [3:0]   i4, g_idx;
   logic [5:0]   g5, g3, g7;
   logic [31:0]  f_val, t_sum, rot_val;
   logic [63:0]  rot_wide;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign rsp_take    = rsp_valid_ff && !rsp_stall;
   assign out_free    = (!rsp_valid_ff || rsp_take) && !hi_pend_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign used        = count_ff[5:0];
   assign bit_len     = {count_ff, 3'b000};

   // round step datapath
   assign rnd = step_ff[5:4];
   assign i4  = step_ff[3:0];
   assign g5  = {i4, 2'b00} + {2'b00, i4} + 6'd1;
   assign g3  = {1'b0, i4, 1'b0} + {2'b00, i4} + 6'd5;
   assign g7  = {i4, 2'b00} + {1'b0, i4, 1'b0} + {2'b00, i4};

   always_comb begin
      case (rnd)
         2'd0: begin
            f_val = wd_ff ^ (wb_ff & (wc_ff ^ wd_ff));
            g_idx = i4;
         end
         2'd1: begin
            f_val = wc_ff ^ (wd_ff & (wb_ff ^ wc_ff));
            g_idx = g5[3:0];
         end
         2'd2: begin
            f_val = wb_ff ^ wc_ff ^ wd_ff;
            g_idx = g3[3:0];
         end
         default: begin
            f_val = wc_ff ^ (wb_ff | ~wd_ff);
            g_idx = g7[3:0];
         end
      endcase
   end

   assign t_sum    = wa_ff + f_val + K_TABLE[step_ff] + block_ff[g_idx];
   assign rot_wide = {t_sum, t_sum} << S_TABLE[{rnd, step_ff[1:0]}];
   assign rot_val  = rot_wide[63:32];

   always_comb begin
      state_in     = state_ff;
      chain_a_in   = chain_a_ff;
      chain_b_in   = chain_b_ff;
      chain_c_in   = chain_c_ff;
      chain_d_in   = chain_d_ff;
      wa_in        = wa_ff;
      wb_in        = wb_ff;
      wc_in        = wc_ff;
      wd_in        = wd_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      k_in         = k_ff;
      fin_in       = fin_ff;
      len_in       = len_ff;
      pend_last_in = pend_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      hi_in        = hi_ff;
      hi_pend_in   = hi_pend_ff;
      wr_en        = 1'b0;
      wr_idx       = used[5:2];
      wr_be        = 4'b0000;
      wr_data      = 32'd0;

      // advance the digest halves
      if (rsp_take) begin
         if (hi_pend_ff) begin
            rsp_in     = '{digest_part: hi_ff, part_last: 1'b1};
            hi_pend_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_payload.has_byte) begin
                  wr_en    = 1'b1;
                  wr_be    = 4'b0001 << used[1:0];
                  wr_data  = {4{req_payload.data_byte}};
                  count_in = count_ff + 61'd1;
                  if (used == 6'd63) begin
                     pend_last_in = req_payload.is_last;
                     wa_in        = chain_a_ff;
                     wb_in        = chain_b_ff;
                     wc_in        = chain_c_ff;
                     wd_in        = chain_d_ff;
                     step_in      = 6'd0;
                     state_in     = ST_ROUND;
                  end else if (req_payload.is_last) begin
                     state_in = ST_MARK;
                  end
               end else if (req_payload.is_last) begin
                  state_in = ST_MARK;
               end
            end
         end
         ST_ROUND: begin
            wa_in   = wd_ff;
            wb_in   = wb_ff + rot_val;
            wc_in   = wb_ff;
            wd_in   = wc_ff;
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd63) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            chain_a_in = chain_a_ff + wa_ff;
            chain_b_in = chain_b_ff + wb_ff;
            chain_c_in = chain_c_ff + wc_ff;
            chain_d_in = chain_d_ff + wd_ff;
            if (fin_ff) begin
               if (len_ff) begin
                  state_in = ST_DONE;
               end else begin
                  k_in     = 5'd0;
                  len_in   = 1'b1;
                  state_in = ST_FILL;
               end
            end else if (pend_last_ff) begin
               pend_last_in = 1'b0;
               state_in     = ST_MARK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MARK: begin
            // keep lanes below the mark, place 0x80, clear the lanes above
            wr_en    = 1'b1;
            wr_be    = 4'b1111 << used[1:0];
            wr_data  = {24'd0, PAD_MARK} << {used[1:0], 3'b000};
            k_in     = {1'b0, used[5:2]} + 5'd1;
            len_in   = (used[5:3] != 3'b111);
            fin_in   = 1'b1;
            state_in = ST_FILL;
         end
         ST_FILL: begin
            if (k_ff[4]) begin
               wa_in    = chain_a_ff;
               wb_in    = chain_b_ff;
               wc_in    = chain_c_ff;
               wd_in    = chain_d_ff;
               step_in  = 6'd0;
               state_in = ST_ROUND;
            end else begin
               wr_en  = 1'b1;
               wr_idx = k_ff[3:0];
               wr_be  = 4'b1111;
               if (len_ff && k_ff[3:0] == 4'd14) begin
                  wr_data = bit_len[31:0];
               end else if (len_ff && k_ff[3:0] == 4'd15) begin
                  wr_data = bit_len[63:32];
               end
               k_in = k_ff + 5'd1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{digest_part: {chain_b_ff, chain_a_ff}, part_last: 1'b0};
               hi_in        = {chain_d_ff, chain_c_ff};
               hi_pend_in   = 1'b1;
               chain_a_in   = IV_A;
               chain_b_in   = IV_B;
               chain_c_in   = IV_C;
               chain_d_in   = IV_D;
               count_in     = 61'd0;
               fin_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chain_a_ff   <= IV_A;
         chain_b_ff   <= IV_B;
         chain_c_ff   <= IV_C;
         chain_d_ff   <= IV_D;
         count_ff     <= 61'd0;
         fin_ff       <= 1'b0;
         len_ff       <= 1'b0;
         pend_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hi_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chain_a_ff   <= chain_a_in;
         chain_b_ff   <= chain_b_in;
         chain_c_ff   <= chain_c_in;
         chain_d_ff   <= chain_d_in;
         count_ff     <= count_in;
         fin_ff       <= fin_in;
         len_ff       <= len_in;
         pend_last_ff <= pend_last_in;
         rsp_valid_ff <= rsp_valid_in;
         hi_pend_ff   <= hi_pend_in;
      end
      wa_ff   <= wa_in;
      wb_ff   <= wb_in;
      wc_ff   <= wc_in;
      wd_ff   <= wd_in;
      step_ff <= step_in;
      k_ff    <= k_in;
      rsp_ff  <= rsp_in;
      hi_ff   <= hi_in;
   end

   // block buffer, byte-lane writes
   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int j = 0; j < 4; j++) begin
            if (wr_be[j]) begin
               block_ff[wr_idx][8*j +: 8] <= wr_data[8*j +: 8];
            end
         end
      end
   end

`ifndef SYNTHESIS
   a_first_half_leads: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && hi_pend_ff) |-> !rsp_ff.part_last)
      else $error("second digest half shown while it is still queued");

   a_second_half_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && hi_pend_ff && !rsp_stall) |=> (rsp_valid_ff && rsp_ff.part_last))
      else $error("second digest half did not follow the first");

   a_no_double_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && rsp_ff.part_last) |=>
      !(rsp_valid_ff && rsp_ff.part_last))
      else $error("second digest half repeated");
`endif

endmodule
